[rtl/fractional_delay_fir_core_assert.svh]
// ----------------------------------------------------------------------------
// Fractional-delay FIR assertion macros
// Shared concurrent assertion forms, checked on the rising clock edge with
// the synchronous reset masking the check.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_FIR_CORE_ASSERT_SVH
`define FRACTIONAL_DELAY_FIR_CORE_ASSERT_SVH

// Same-cycle implication
`define FDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_pkg
// Types and constants shared by the fractional-delay FIR modules.
// ----------------------------------------------------------------------------
package fdf_pkg;

  // Sizes
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int FRAC_BITS   = 15;
  localparam int TAPS        = 4;
  localparam int TAP_BITS    = 2;
  localparam int PTR_BITS    = 10;
  localparam int RING_DEPTH  = 1 << PTR_BITS;
  localparam int ROW_BITS    = PTR_BITS - TAP_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS    = PROD_BITS + TAP_BITS;
  localparam int Y_BITS      = ACC_BITS - FRAC_BITS;
  localparam int CFG_IDX_BITS = 3;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY      = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ZERO  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ONE   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TWO   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_THREE = 3'd4;

  // Types
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [PTR_BITS-1:0]           ptr_t;
  typedef logic [ROW_BITS-1:0]           row_t;
  typedef logic [TAP_BITS-1:0]           tap_idx_t;

  // Stage advance enables, handed from the pipeline control to the datapath
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } adv_t;

  localparam coef_t   COEF_ZERO_RESET = 16'sh7FFF;
  localparam sample_t SAMPLE_MAX      = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN      = 16'sh8000;

endpackage

[rtl/fdf_bank.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_bank
// One bank of the history ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fdf_bank (
  input  logic             clk,
  input  logic             wr_en,
  input  fdf_pkg::row_t    wr_row,
  input  fdf_pkg::sample_t wr_data,
  input  logic             rd_en,
  input  fdf_pkg::row_t    rd_row,
  output fdf_pkg::sample_t rd_data
);

  localparam int ROWS = 1 << fdf_pkg::ROW_BITS;

  fdf_pkg::sample_t mem [ROWS];

  // Read returns the contents before a same-edge write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

[rtl/fdf_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_ring
// History ring split into one bank per tap. The taps sit at consecutive
// addresses, so each bank serves exactly one tap per sample. Entries not yet
// written since reset read as zero, tracked by the write pointer and a
// wrap flag.
// ----------------------------------------------------------------------------
module fdf_ring (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  fdf_pkg::sample_t wr_data,
  input  logic             adv1,
  input  fdf_pkg::ptr_t    delay,
  output fdf_pkg::sample_t taps [fdf_pkg::TAPS]
);

  fdf_pkg::ptr_t    wp;
  fdf_pkg::ptr_t    wp_next;
  logic             wrapped;
  fdf_pkg::ptr_t    base;
  fdf_pkg::sample_t rd_data [fdf_pkg::TAPS];
  logic [fdf_pkg::TAPS-1:0] rd_valid;
  logic [fdf_pkg::TAPS-1:0] rd_valid_next;
  logic [fdf_pkg::TAPS-1:0] rd_hit;
  logic [fdf_pkg::TAPS-1:0] rd_hit_next;
  fdf_pkg::row_t    rd_row [fdf_pkg::TAPS];
  fdf_pkg::tap_idx_t base_lo;
  fdf_pkg::sample_t samp_q;

  // Write pointer and wrap flag
  assign wp_next = wp + fdf_pkg::PTR_BITS'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (wr_en) begin
      wp <= wp_next;
      if (&wp) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Newest tap address; tap k sits k entries further back
  assign base = wp - delay;

  // Per-bank read address, written flag and same-edge write hit
  for (genvar b = 0; b < fdf_pkg::TAPS; b++) begin : g_bank
    fdf_pkg::tap_idx_t k_sel;
    fdf_pkg::ptr_t     addr;

    assign k_sel = base[fdf_pkg::TAP_BITS-1:0] - fdf_pkg::tap_idx_t'(b);
    assign addr  = base - {{(fdf_pkg::PTR_BITS-fdf_pkg::TAP_BITS){1'b0}}, k_sel};
    assign rd_row[b]        = addr[fdf_pkg::PTR_BITS-1:fdf_pkg::TAP_BITS];
    assign rd_valid_next[b] = wrapped || (addr < wp);
    assign rd_hit_next[b]   = (addr == wp);

    fdf_bank u_bank (
      .clk     (clk),
      .wr_en   (wr_en && (wp[fdf_pkg::TAP_BITS-1:0] == fdf_pkg::tap_idx_t'(b))),
      .wr_row  (wp[fdf_pkg::PTR_BITS-1:fdf_pkg::TAP_BITS]),
      .wr_data (wr_data),
      .rd_en   (adv1),
      .rd_row  (rd_row[b]),
      .rd_data (rd_data[b])
    );
  end

  // Stage 1 side info, held with the bank read data
  always_ff @(posedge clk) begin
    if (adv1) begin
      rd_valid <= rd_valid_next;
      rd_hit   <= rd_hit_next;
      base_lo  <= base[fdf_pkg::TAP_BITS-1:0];
      samp_q   <= wr_data;
    end
  end

  // Route banks back to taps; bypass the sample written on the same edge
  for (genvar k = 0; k < fdf_pkg::TAPS; k++) begin : g_tap
    fdf_pkg::tap_idx_t bsel;

    assign bsel = base_lo - fdf_pkg::tap_idx_t'(k);

    always_comb begin
      priority if (rd_hit[bsel]) begin
        taps[k] = samp_q;
      end else if (rd_valid[bsel]) begin
        taps[k] = rd_data[bsel];
      end else begin
        taps[k] = '0;
      end
    end
  end

endmodule

[rtl/fdf_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_mac
// Tap products, then sum, round half up and saturate to the sample width.
// ----------------------------------------------------------------------------
module fdf_mac (
  input  logic             clk,
  input  fdf_pkg::adv_t    adv,
  input  fdf_pkg::sample_t taps [fdf_pkg::TAPS],
  input  fdf_pkg::coef_t   coefs [fdf_pkg::TAPS],
  output fdf_pkg::sample_t sample_out,
  output logic             saturated
);

  fdf_pkg::prod_t prod [fdf_pkg::TAPS];
  logic signed [fdf_pkg::ACC_BITS-1:0] acc;
  logic signed [fdf_pkg::ACC_BITS-1:0] acc_rnd;
  logic signed [fdf_pkg::Y_BITS-1:0]   y;
  logic             sat_hi;
  logic             sat_lo;
  fdf_pkg::sample_t sample_next;

  // Stage 2: one multiplier per tap
  always_ff @(posedge clk) begin
    if (adv.adv2) begin
      for (int k = 0; k < fdf_pkg::TAPS; k++) begin
        prod[k] <= taps[k] * coefs[k];
      end
    end
  end

  // Sum, round half up, drop the fraction bits
  always_comb begin
    acc = '0;
    for (int k = 0; k < fdf_pkg::TAPS; k++) begin
      acc = acc + fdf_pkg::ACC_BITS'(prod[k]);
    end
    acc_rnd = acc + (fdf_pkg::ACC_BITS'(1) <<< (fdf_pkg::FRAC_BITS - 1));
    y       = acc_rnd[fdf_pkg::ACC_BITS-1:fdf_pkg::FRAC_BITS];
  end

  // Clip when the upper bits are not all copies of the sign
  assign sat_hi = !y[fdf_pkg::Y_BITS-1] &&
                  (|y[fdf_pkg::Y_BITS-2:fdf_pkg::SAMPLE_BITS-1]);
  assign sat_lo = y[fdf_pkg::Y_BITS-1] &&
                  !(&y[fdf_pkg::Y_BITS-2:fdf_pkg::SAMPLE_BITS-1]);

  always_comb begin
    priority if (sat_hi) begin
      sample_next = fdf_pkg::SAMPLE_MAX;
    end else if (sat_lo) begin
      sample_next = fdf_pkg::SAMPLE_MIN;
    end else begin
      sample_next = y[fdf_pkg::SAMPLE_BITS-1:0];
    end
  end

  // Stage 3: result register
  always_ff @(posedge clk) begin
    if (adv.adv3) begin
      sample_out <= sample_next;
      saturated  <= sat_hi || sat_lo;
    end
  end

endmodule

[rtl/fractional_delay_fir_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_delay_fir_core
// One audio channel of a fractional sample delay: history ring plus a
// four-tap FIR with software-supplied integer delay and coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input samples arrive on sample_in with in_valid/in_stall; one result per
//   input leaves on sample_out/saturated with out_valid/out_stall. A transfer
//   happens on an edge where valid is high and stall is low.
//   Path from the input transfer to out_valid: ring read, tap multiply,
//   sum/round/saturate. Throughput: one sample per cycle while out_stall
//   is low; each ring bank takes one read per sample, and one bank takes the write.
//   When out_stall holds the result register, earlier stages keep filling
//   until they are occupied, then in_stall rises.
//   Reset clears the pipeline, the write pointer, the delay (0) and the
//   coefficients (tap 0 at full scale, others zero). The ring is not swept:
//   entries not yet written since reset read as zero.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect on the
//   next edge and belong in idle periods; unknown indexes are dropped.
//   Feeding zero samples drains the filter tail.
// ----------------------------------------------------------------------------
`include "fractional_delay_fir_core_assert.svh"

module fractional_delay_fir_core (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write port
  input  logic                             cfg_write,
  input  logic [fdf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [fdf_pkg::COEF_BITS-1:0]    cfg_data,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  fdf_pkg::sample_t                 sample_in,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output fdf_pkg::sample_t                 sample_out,
  output logic                             saturated
);

  fdf_pkg::ptr_t    delay;
  fdf_pkg::coef_t   coefs [fdf_pkg::TAPS];
  fdf_pkg::sample_t taps  [fdf_pkg::TAPS];
  fdf_pkg::adv_t    adv;
  logic             accept;
  logic             v1;
  logic             v2;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay    <= '0;
      coefs[0] <= fdf_pkg::COEF_ZERO_RESET;
      coefs[1] <= '0;
      coefs[2] <= '0;
      coefs[3] <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fdf_pkg::REG_DELAY:      delay    <= cfg_data[fdf_pkg::PTR_BITS-1:0];
        fdf_pkg::REG_COEF_ZERO:  coefs[0] <= cfg_data;
        fdf_pkg::REG_COEF_ONE:   coefs[1] <= cfg_data;
        fdf_pkg::REG_COEF_TWO:   coefs[2] <= cfg_data;
        fdf_pkg::REG_COEF_THREE: coefs[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pipeline control: a stage moves when its successor is empty or moving
  assign adv.adv3 = !out_valid || !out_stall;
  assign adv.adv2 = !v2 || adv.adv3;
  assign adv.adv1 = !v1 || adv.adv2;
  assign in_stall = !adv.adv1;
  assign accept   = in_valid && adv.adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv.adv1) begin
        v1 <= accept;
      end
      if (adv.adv2) begin
        v2 <= v1;
      end
      if (adv.adv3) begin
        out_valid <= v2;
      end
    end
  end

  // Ring write and tap reads (stage 1)
  fdf_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (sample_in),
    .adv1    (adv.adv1),
    .delay   (delay),
    .taps    (taps)
  );

  // Products and output (stages 2 and 3)
  fdf_mac u_mac (
    .clk        (clk),
    .adv        (adv),
    .taps       (taps),
    .coefs      (coefs),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  // Checks
  `FDF_ASSERT_NOW(a_empty_out_takes_input, clk, rst, !out_valid, !in_stall, "input stalled with empty output register")
  `FDF_ASSERT_NEXT(a_pipe_refills_out, clk, rst, out_valid && !out_stall && v2, out_valid, "queued result not moved to output")
  `FDF_ASSERT_NOW(a_sat_at_rail, clk, rst, out_valid && saturated, (sample_out == fdf_pkg::SAMPLE_MAX) || (sample_out == fdf_pkg::SAMPLE_MIN), "saturated flag without rail value")

endmodule
